### hdl/boids_flocking_step_unit_defines.svh
// Assertion macros used by the port-level checks of the flocking step unit.
`ifndef BOIDS_FLOCKING_STEP_UNIT_DEFINES_SVH
`define BOIDS_FLOCKING_STEP_UNIT_DEFINES_SVH

// Check that cons holds in the cycle after ante.
`define BFS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("flocking step check failed");

// Check that cons holds in the same cycle as ante.
`define BFS_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("flocking step check failed");

`endif

### hdl/bfs_pkg.sv
// Shared constants and codes of the flocking step unit.
`timescale 1ns / 1ps
`default_nettype none
package bfs_pkg;
	localparam int NUM_BOIDS     = 32;
	localparam int IDX_W         = $clog2(NUM_BOIDS);
	localparam int CNT_W         = $clog2(NUM_BOIDS + 1);
	localparam int SCREEN_WIDTH  = 1920;
	localparam int SCREEN_HEIGHT = 1080;
	localparam int BOID_WIDTH    = 8;
	localparam int BOID_HEIGHT   = 8;

	localparam int POS_W = 24;
	localparam int VEL_W = 16;

	// iterative divider: signed numerator, unsigned divisor
	localparam int DIV_NW = 40;
	localparam int DIV_DW = 24;
	// iterative square root: root width, radicand is twice as wide
	localparam int SQ_RW  = 24;
	localparam int SQ_IW  = 2 * SQ_RW;

	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_UPDATE = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [2:0] REG_VISUAL_RANGE   = 3'd0;
	localparam logic [2:0] REG_MIN_DISTANCE   = 3'd1;
	localparam logic [2:0] REG_CENTERING_GAIN = 3'd2;
	localparam logic [2:0] REG_AVOID_GAIN     = 3'd3;
	localparam logic [2:0] REG_MATCHING_GAIN  = 3'd4;
	localparam logic [2:0] REG_MAX_SPEED      = 3'd5;
	localparam logic [2:0] REG_TURN_STEP      = 3'd6;
	localparam logic [2:0] REG_EDGE_MARGIN    = 3'd7;
endpackage
`default_nettype wire

### hdl/bfs_div.sv
// Restoring divider, one quotient bit per cycle, quotient truncated toward zero.
`timescale 1ns / 1ps
`default_nettype none
module bfs_div import bfs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DIV_NW-1:0] num,
	input  logic        [DIV_DW-1:0] den,
	output logic                     done,
	output logic signed [DIV_NW-1:0] quo
);
	localparam int CW = $clog2(DIV_NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [DIV_NW-1:0] n_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, n_q[DIV_NW-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[DIV_NW-1];
			n_q   <= num[DIV_NW-1] ? DIV_NW'(-num) : DIV_NW'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			n_q   <= {n_q[DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(n_q) : $signed(n_q);
endmodule
`default_nettype wire

### hdl/bfs_isqrt.sv
// Integer square root, one root bit per cycle, result floored.
`timescale 1ns / 1ps
`default_nettype none
module bfs_isqrt import bfs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SQ_IW-1:0] rad,
	output logic             done,
	output logic [SQ_RW-1:0] root
);
	localparam int CW = $clog2(SQ_RW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [SQ_IW-1:0] rad_q;
	logic [SQ_RW+1:0] rem_q;
	logic [SQ_RW-1:0] root_q;
	logic [SQ_RW+2:0] trial_rem;
	logic [SQ_RW+2:0] trial;
	logic [SQ_RW+2:0] diff;
	logic             ge;

	always_comb begin
		trial_rem = {rem_q[SQ_RW:0], rad_q[SQ_IW-1:SQ_IW-2]};
		trial     = {1'b0, root_q, 2'b01};
		ge        = trial_rem >= trial;
		diff      = trial_rem - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SQ_RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQ_IW-3:0], 2'b00};
			rem_q  <= ge ? diff[SQ_RW+1:0] : trial_rem[SQ_RW+1:0];
			root_q <= {root_q[SQ_RW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

### hdl/boids_flocking_step_unit.sv
// Flocking step unit: a stored set of boids updated by one shared multiplier, divider and root.
// Load and clear items are handled in the idle state. An update of N stored boids runs, per
// boid, a neighbour scan on the multiplier, up to six divides and one root; once every boid
// is written back, the results leave one boid per output transfer.
// Input is not ready for the whole update. Reset clears the boid count and the handshakes
// and restores the register defaults; the boid stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module boids_flocking_step_unit import bfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // in_pos_x, in_pos_y, in_vel_x, in_vel_y
	input  logic [1:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // boid_index, new_pos_x, new_pos_y, new_vel_x, new_vel_y
	output logic        m_tlast,   // last_boid
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [23:0] cfg_wdata
);
	// working widths
	localparam int DX_W    = POS_W + 1;               // position difference
	localparam int ACC_P_W = POS_W + IDX_W;           // position sum
	localparam int ACC_V_W = VEL_W + IDX_W;           // velocity sum
	localparam int ACC_O_W = DX_W + IDX_W;            // separation sum
	localparam int VA_W    = POS_W + IDX_W + 4;       // unsaturated velocity
	localparam int MA_W    = VA_W + 1;                // multiplier operand a
	localparam int MB_W    = DX_W;                    // multiplier operand b
	localparam int MP_W    = MA_W + MB_W;             // product
	localparam int D2_W    = 2 * DX_W;                // squared distance
	localparam int R2_W    = 2 * POS_W;               // squared radius
	localparam int S2_W    = SQ_IW - 16;              // squared speed
	localparam int MG_W    = 28;                      // margin compare width
	localparam int VEL_MAX = 2 ** (VEL_W - 1) - 1;
	localparam int POS_MAX = 2 ** (POS_W - 1) - 1;

	typedef enum logic [5:0] {
		ST_IDLE, ST_PRE_VR, ST_PRE_MD, ST_PRE_MS, ST_SELF_RD, ST_SELF_LD,
		ST_NB_RD, ST_NB_DIFF, ST_NB_SQX, ST_NB_SQY,
		ST_CX_DIV, ST_CX_MUL, ST_CY_DIV, ST_CY_MUL, ST_OX_MUL, ST_OY_MUL,
		ST_MX_DIV, ST_MX_MUL, ST_MY_DIV, ST_MY_MUL, ST_SAT,
		ST_SPX, ST_SPY, ST_SQRT, ST_LX_MUL, ST_LX_DIV, ST_LY_MUL, ST_LY_DIV,
		ST_MARGIN, ST_WB, ST_EM_RD, ST_EM_LD
	} state_t;

	function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VA_W-1:0] v);
		if (v > $signed(VA_W'(VEL_MAX)))
			return VEL_W'(VEL_MAX);
		else if (v < -$signed(VA_W'(VEL_MAX)) - 1)
			return VEL_W'(-VEL_MAX - 1);
		else
			return VEL_W'(v);
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
		if (v > $signed((POS_W + 1)'(POS_MAX)))
			return POS_W'(POS_MAX);
		else if (v < -$signed((POS_W + 1)'(POS_MAX)) - 1)
			return POS_W'(-POS_MAX - 1);
		else
			return POS_W'(v);
	endfunction

	// configuration registers
	logic [23:0] vr_q, md_q;
	logic [15:0] cg_q, ag_q, mg_q;
	logic [14:0] ms_q, ts_q;
	logic [11:0] em_q;

	// sequencer
	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] s_q;
	logic [CNT_W-1:0] i_q;
	logic             go_q;
	logic             m_tvalid_q;

	// boid stores
	logic signed [POS_W-1:0] mem_px [NUM_BOIDS];
	logic signed [POS_W-1:0] mem_py [NUM_BOIDS];
	logic signed [VEL_W-1:0] mem_vx [NUM_BOIDS];
	logic signed [VEL_W-1:0] mem_vy [NUM_BOIDS];
	logic                    mem_we;
	logic [IDX_W-1:0]        mem_waddr;
	logic signed [POS_W-1:0] w_px, w_py;
	logic signed [VEL_W-1:0] w_vx, w_vy;
	logic                    rd_en;
	logic [IDX_W-1:0]        rd_addr;
	logic signed [POS_W-1:0] rd_px, rd_py;
	logic signed [VEL_W-1:0] rd_vx, rd_vy;

	// datapath registers
	logic signed [POS_W-1:0]   px_q, py_q;
	logic signed [VA_W-1:0]    vxa_q, vya_q;
	logic signed [DX_W-1:0]    dx_q, dy_q;
	logic [D2_W-1:0]           d2_q;
	logic [R2_W-1:0]           vr2_q, md2_q;
	logic [S2_W-1:0]           ms2_q, s2_q;
	logic signed [ACC_P_W-1:0] cx_q, cy_q;
	logic signed [ACC_V_W-1:0] mx_q, my_q;
	logic signed [ACC_O_W-1:0] ox_q, oy_q;
	logic [CNT_W-1:0]          nb_q;
	logic signed [DIV_NW-1:0]  quo_q;
	logic signed [DIV_NW-1:0]  lim_q;
	logic [SQ_RW-1:0]          sp_q;
	logic [5:0]                o_idx_q;
	logic signed [POS_W-1:0]   o_px_q, o_py_q;
	logic signed [VEL_W-1:0]   o_vx_q, o_vy_q;
	logic                      o_last_q;

	// shared units
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [MP_W-1:0]   mul_p;
	logic signed [MP_W-1:0]   gain_rnd;
	logic signed [MP_W-1:0]   gain_p;
	logic                     div_start;
	logic signed [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0]        div_den;
	logic                     div_done;
	logic signed [DIV_NW-1:0] div_quo;
	logic                     sq_start;
	logic                     sq_done;
	logic [SQ_RW-1:0]         sq_root;

	// combinational helpers
	logic                     in_acc;
	logic [D2_W-1:0]          d2_sum;
	logic [S2_W-1:0]          s2_sum;
	logic                     is_last;
	logic signed [MG_W-1:0]   px_m, py_m, em_m, hx_m, hy_m;
	logic signed [VA_W-1:0]   nudge_x, nudge_y;
	logic signed [POS_W:0]    npx_w, npy_w;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = 88'({o_vy_q, o_vx_q, o_py_q, o_px_q, o_idx_q});

	assign d2_sum  = d2_q + D2_W'(mul_p);
	assign s2_sum  = s2_q + S2_W'(mul_p);
	assign is_last = (i_q + 1'b1) == count_q;

	// configuration writes; indexes map one to one onto the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vr_q <= 24'd10240;
			md_q <= 24'd2048;
			cg_q <= 16'd33;
			ag_q <= 16'd3277;
			mg_q <= 16'd3277;
			ms_q <= 15'd1536;
			ts_q <= 15'd51;
			em_q <= 12'd100;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_VISUAL_RANGE:   vr_q <= cfg_wdata;
				REG_MIN_DISTANCE:   md_q <= cfg_wdata;
				REG_CENTERING_GAIN: cg_q <= cfg_wdata[15:0];
				REG_AVOID_GAIN:     ag_q <= cfg_wdata[15:0];
				REG_MATCHING_GAIN:  mg_q <= cfg_wdata[15:0];
				REG_MAX_SPEED:      ms_q <= cfg_wdata[14:0];
				REG_TURN_STEP:      ts_q <= cfg_wdata[14:0];
				REG_EDGE_MARGIN:    em_q <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	// Shared multiplier: operands follow the sequencer step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_PRE_VR: begin
				mul_a = MA_W'(vr_q);
				mul_b = MB_W'(vr_q);
			end
			ST_PRE_MD: begin
				mul_a = MA_W'(md_q);
				mul_b = MB_W'(md_q);
			end
			ST_PRE_MS: begin
				mul_a = MA_W'(ms_q);
				mul_b = MB_W'(ms_q);
			end
			ST_NB_SQX: begin
				mul_a = MA_W'(dx_q);
				mul_b = dx_q;
			end
			ST_NB_SQY: begin
				mul_a = MA_W'(dy_q);
				mul_b = dy_q;
			end
			ST_CX_MUL: begin
				mul_a = MA_W'(quo_q) - MA_W'(px_q);
				mul_b = MB_W'(cg_q);
			end
			ST_CY_MUL: begin
				mul_a = MA_W'(quo_q) - MA_W'(py_q);
				mul_b = MB_W'(cg_q);
			end
			ST_OX_MUL: begin
				mul_a = MA_W'(ox_q);
				mul_b = MB_W'(ag_q);
			end
			ST_OY_MUL: begin
				mul_a = MA_W'(oy_q);
				mul_b = MB_W'(ag_q);
			end
			ST_MX_MUL: begin
				mul_a = MA_W'(quo_q) - MA_W'(vxa_q);
				mul_b = MB_W'(mg_q);
			end
			ST_MY_MUL: begin
				mul_a = MA_W'(quo_q) - MA_W'(vya_q);
				mul_b = MB_W'(mg_q);
			end
			ST_SPX: begin
				mul_a = MA_W'($signed(vxa_q[VEL_W-1:0]));
				mul_b = MB_W'($signed(vxa_q[VEL_W-1:0]));
			end
			ST_SPY: begin
				mul_a = MA_W'($signed(vya_q[VEL_W-1:0]));
				mul_b = MB_W'($signed(vya_q[VEL_W-1:0]));
			end
			ST_LX_MUL: begin
				mul_a = MA_W'($signed(vxa_q[VEL_W-1:0]));
				mul_b = MB_W'(ms_q);
			end
			ST_LY_MUL: begin
				mul_a = MA_W'($signed(vya_q[VEL_W-1:0]));
				mul_b = MB_W'(ms_q);
			end
			default: ;
		endcase
		mul_p    = mul_a * mul_b;
		// gain products drop 16 fraction bits, truncating toward zero
		gain_rnd = mul_p + $signed(MP_W'(mul_p[MP_W-1] ? 65535 : 0));
		gain_p   = gain_rnd >>> 16;
	end

	// Shared divider: means over the neighbours, then the speed rescale.
	always_comb begin
		div_num = lim_q;
		div_den = DIV_DW'(nb_q);
		case (state_q)
			ST_CX_DIV: div_num = DIV_NW'(cx_q);
			ST_CY_DIV: div_num = DIV_NW'(cy_q);
			ST_MX_DIV: div_num = DIV_NW'(mx_q);
			ST_MY_DIV: div_num = DIV_NW'(my_q);
			ST_LX_DIV, ST_LY_DIV: begin
				div_num = lim_q;
				div_den = sp_q;
			end
			default: ;
		endcase
	end

	assign div_start = !go_q && (state_q == ST_CX_DIV || state_q == ST_CY_DIV ||
		state_q == ST_MX_DIV || state_q == ST_MY_DIV ||
		state_q == ST_LX_DIV || state_q == ST_LY_DIV);
	assign sq_start  = !go_q && (state_q == ST_SQRT);

	bfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	bfs_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    ({s2_q, 16'b0}),
		.done   (sq_done),
		.root   (sq_root)
	);

	// Margin tests use the position from the start of this boid's update.
	always_comb begin
		px_m = MG_W'(px_q);
		py_m = MG_W'(py_q);
		em_m = MG_W'({em_q, 8'b0});
		hx_m = MG_W'(SCREEN_WIDTH * 256) - em_m;
		hy_m = MG_W'(SCREEN_HEIGHT * 256) - em_m;
		nudge_x = '0;
		nudge_y = '0;
		if (px_m < em_m)
			nudge_x = nudge_x + VA_W'(ts_q);
		if (px_m + MG_W'(BOID_WIDTH * 256) > hx_m)
			nudge_x = nudge_x - VA_W'(ts_q);
		if (py_m < em_m)
			nudge_y = nudge_y + VA_W'(ts_q);
		if (py_m + MG_W'(BOID_HEIGHT * 256) > hy_m)
			nudge_y = nudge_y - VA_W'(ts_q);
		npx_w = (POS_W + 1)'(px_q) + (POS_W + 1)'($signed(vxa_q[VEL_W-1:0]));
		npy_w = (POS_W + 1)'(py_q) + (POS_W + 1)'($signed(vya_q[VEL_W-1:0]));
	end

	// Store ports: loads append at the count, the update writes back in place.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		w_px      = $signed(s_tdata[23:0]);
		w_py      = $signed(s_tdata[47:24]);
		w_vx      = $signed(s_tdata[63:48]);
		w_vy      = $signed(s_tdata[79:64]);
		if (state_q == ST_WB) begin
			mem_we    = 1'b1;
			mem_waddr = s_q[IDX_W-1:0];
			w_px      = sat_pos(npx_w);
			w_py      = sat_pos(npy_w);
			w_vx      = vxa_q[VEL_W-1:0];
			w_vy      = vya_q[VEL_W-1:0];
		end else if (in_acc && s_tuser == MODE_LOAD && count_q < CNT_W'(NUM_BOIDS)) begin
			mem_we = 1'b1;
		end
		rd_en   = 1'b0;
		rd_addr = i_q[IDX_W-1:0];
		case (state_q)
			ST_SELF_RD: begin
				rd_en   = 1'b1;
				rd_addr = s_q[IDX_W-1:0];
			end
			ST_NB_RD: rd_en = (i_q != count_q) && (i_q != s_q);
			ST_EM_RD: rd_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_px[mem_waddr] <= w_px;
			mem_py[mem_waddr] <= w_py;
			mem_vx[mem_waddr] <= w_vx;
			mem_vy[mem_waddr] <= w_vy;
		end
		if (rd_en) begin
			rd_px <= mem_px[rd_addr];
			rd_py <= mem_py[rd_addr];
			rd_vx <= mem_vx[rd_addr];
			rd_vy <= mem_vy[rd_addr];
		end
	end

	// Sequencer and handshake registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			s_q        <= '0;
			i_q        <= '0;
			go_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (s_tuser)
							MODE_LOAD: begin
								if (count_q < CNT_W'(NUM_BOIDS))
									count_q <= count_q + 1'b1;
							end
							MODE_CLEAR: count_q <= '0;
							MODE_UPDATE: begin
								if (count_q != '0) begin
									s_q     <= '0;
									state_q <= ST_PRE_VR;
								end
							end
							default: ;
						endcase
					end
				end
				ST_PRE_VR:  state_q <= ST_PRE_MD;
				ST_PRE_MD:  state_q <= ST_PRE_MS;
				ST_PRE_MS:  state_q <= ST_SELF_RD;
				ST_SELF_RD: state_q <= ST_SELF_LD;
				ST_SELF_LD: begin
					i_q     <= '0;
					state_q <= ST_NB_RD;
				end
				ST_NB_RD: begin
					if (i_q == count_q)
						state_q <= (nb_q != '0) ? ST_CX_DIV : ST_OX_MUL;
					else if (i_q == s_q)
						i_q <= i_q + 1'b1;
					else
						state_q <= ST_NB_DIFF;
				end
				ST_NB_DIFF: state_q <= ST_NB_SQX;
				ST_NB_SQX:  state_q <= ST_NB_SQY;
				ST_NB_SQY: begin
					i_q     <= i_q + 1'b1;
					state_q <= ST_NB_RD;
				end
				ST_CX_DIV, ST_CY_DIV, ST_MX_DIV, ST_MY_DIV, ST_LX_DIV, ST_LY_DIV: begin
					if (!go_q) begin
						go_q <= 1'b1;
					end else if (div_done) begin
						go_q <= 1'b0;
						case (state_q)
							ST_CX_DIV: state_q <= ST_CX_MUL;
							ST_CY_DIV: state_q <= ST_CY_MUL;
							ST_MX_DIV: state_q <= ST_MX_MUL;
							ST_MY_DIV: state_q <= ST_MY_MUL;
							ST_LX_DIV: state_q <= ST_LY_MUL;
							default:   state_q <= ST_MARGIN;
						endcase
					end
				end
				ST_CX_MUL: state_q <= ST_CY_DIV;
				ST_CY_MUL: state_q <= ST_OX_MUL;
				ST_OX_MUL: state_q <= ST_OY_MUL;
				ST_OY_MUL: state_q <= (nb_q != '0) ? ST_MX_DIV : ST_SAT;
				ST_MX_MUL: state_q <= ST_MY_DIV;
				ST_MY_MUL: state_q <= ST_SAT;
				ST_SAT:    state_q <= ST_SPX;
				ST_SPX:    state_q <= ST_SPY;
				ST_SPY:    state_q <= (s2_sum > ms2_q) ? ST_SQRT : ST_MARGIN;
				ST_SQRT: begin
					if (!go_q) begin
						go_q <= 1'b1;
					end else if (sq_done) begin
						go_q    <= 1'b0;
						state_q <= ST_LX_MUL;
					end
				end
				ST_LX_MUL: state_q <= ST_LX_DIV;
				ST_LY_MUL: state_q <= ST_LY_DIV;
				ST_MARGIN: state_q <= ST_WB;
				ST_WB: begin
					if ((s_q + 1'b1) == count_q) begin
						i_q     <= '0;
						state_q <= ST_EM_RD;
					end else begin
						s_q     <= s_q + 1'b1;
						state_q <= ST_SELF_RD;
					end
				end
				ST_EM_RD: state_q <= ST_EM_LD;
				ST_EM_LD: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_EM_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_PRE_VR: vr2_q <= R2_W'(mul_p);
			ST_PRE_MD: md2_q <= R2_W'(mul_p);
			ST_PRE_MS: ms2_q <= S2_W'(mul_p);
			ST_SELF_LD: begin
				px_q  <= rd_px;
				py_q  <= rd_py;
				vxa_q <= VA_W'(rd_vx);
				vya_q <= VA_W'(rd_vy);
				cx_q  <= '0;
				cy_q  <= '0;
				mx_q  <= '0;
				my_q  <= '0;
				ox_q  <= '0;
				oy_q  <= '0;
				nb_q  <= '0;
			end
			ST_NB_DIFF: begin
				dx_q <= DX_W'(rd_px) - DX_W'(px_q);
				dy_q <= DX_W'(rd_py) - DX_W'(py_q);
			end
			ST_NB_SQX: d2_q <= D2_W'(mul_p);
			ST_NB_SQY: begin
				if (d2_sum < D2_W'(vr2_q)) begin
					cx_q <= cx_q + ACC_P_W'(rd_px);
					cy_q <= cy_q + ACC_P_W'(rd_py);
					mx_q <= mx_q + ACC_V_W'(rd_vx);
					my_q <= my_q + ACC_V_W'(rd_vy);
					nb_q <= nb_q + 1'b1;
				end
				if (d2_sum < D2_W'(md2_q)) begin
					ox_q <= ox_q - ACC_O_W'(dx_q);
					oy_q <= oy_q - ACC_O_W'(dy_q);
				end
			end
			ST_CX_DIV, ST_CY_DIV, ST_MX_DIV, ST_MY_DIV: begin
				if (div_done)
					quo_q <= div_quo;
			end
			ST_LX_DIV: begin
				if (div_done)
					vxa_q <= VA_W'(div_quo);
			end
			ST_LY_DIV: begin
				if (div_done)
					vya_q <= VA_W'(div_quo);
			end
			ST_CX_MUL, ST_OX_MUL, ST_MX_MUL: vxa_q <= vxa_q + VA_W'(gain_p);
			ST_CY_MUL, ST_OY_MUL, ST_MY_MUL: vya_q <= vya_q + VA_W'(gain_p);
			ST_SAT: begin
				vxa_q <= VA_W'(sat_vel(vxa_q));
				vya_q <= VA_W'(sat_vel(vya_q));
			end
			ST_SPX: s2_q <= S2_W'(mul_p);
			ST_SPY: s2_q <= s2_sum;
			ST_SQRT: begin
				if (sq_done)
					sp_q <= sq_root;
			end
			// scale by max_speed into Q16.24 so the Q8.16 root divides back to Q8.8
			ST_LX_MUL, ST_LY_MUL: lim_q <= DIV_NW'(mul_p) <<< 8;
			ST_MARGIN: begin
				vxa_q <= VA_W'(sat_vel(vxa_q + nudge_x));
				vya_q <= VA_W'(sat_vel(vya_q + nudge_y));
			end
			ST_EM_LD: begin
				if (!m_tvalid_q || m_tready) begin
					o_idx_q  <= 6'(i_q);
					o_px_q   <= rd_px;
					o_py_q   <= rd_py;
					o_vx_q   <= rd_vx;
					o_vy_q   <= rd_vy;
					o_last_q <= is_last;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### hdl/bfs_chk.sv
// Port-level checks of the flocking step unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "boids_flocking_step_unit_defines.svh"
module bfs_chk import bfs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic        m_tlast
);
	// a held result stays offered
	`BFS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	// a held result keeps its payload
	`BFS_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready,
		$stable(m_tdata) && $stable(m_tlast))
	// load, clear and unknown modes leave the input ready in the next cycle
	`BFS_ASSERT_NEXT(a_quick_modes, clk, arst_n,
		s_tvalid && s_tready && s_tuser != MODE_UPDATE, s_tready)
	// no new item while a step is still emitting
	`BFS_ASSERT_SAME(a_busy_emit, clk, arst_n, m_tvalid && !m_tlast, !s_tready)
endmodule

bind boids_flocking_step_unit bfs_chk u_bfs_chk (.*);
`default_nettype wire
